FILE: design/pfbe_pkg.sv
`timescale 1ns / 1ps

package pfbe_pkg;

   // Command codes carried in the request tuser
   localparam logic [2:0] OP_CLEAR_ALL  = 3'd0;
   localparam logic [2:0] OP_CLEAR_PAGE = 3'd1;
   localparam logic [2:0] OP_WRITE      = 3'd2;
   localparam logic [2:0] OP_BLIT       = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;

   // Configuration register indexes
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Reset values of the configuration registers
   localparam logic [7:0] WIDTH_RESET  = 8'd128;
   localparam logic [6:0] HEIGHT_RESET = 7'd64;

   // Decoded and clipped request, handed from the decoder to the sequencer
   typedef struct packed {
      logic [2:0]  op;     // command code
      logic        ok;     // command is in range and completes with status 0
      logic [2:0]  page;   // target page (first page for a blit)
      logic [6:0]  col;    // target column
      logic [15:0] bits;   // write byte, or blit bits shifted over two pages
      logic [15:0] mask;   // blit mask shifted over two pages
      logic [8:0]  width;  // columns in use after saturation
      logic [4:0]  pages;  // pages in use after saturation
   } pfbe_plan_type;

   // Merge new bits into a stored byte under a mask
   function automatic logic [7:0] pfbe_merge(input logic [7:0] old_byte,
                                             input logic [7:0] new_bits,
                                             input logic [7:0] mask);
      return (new_bits & mask) | (old_byte & ~mask);
   endfunction

endpackage

FILE: design/pfbe_mem.sv
`timescale 1ns / 1ps

module pfbe_mem #(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/pfbe_decode.sv
`timescale 1ns / 1ps

module pfbe_decode import pfbe_pkg::*; #(
   parameter int MAX_COLS  = 128,
   parameter int MAX_PAGES = 8
) (
   input  logic [2:0]    func,
   input  logic [2:0]    page_sel,
   input  logic [6:0]    col_pos,
   input  logic [5:0]    y_pos,
   input  logic [3:0]    bit_count,
   input  logic [7:0]    pix_bits,
   input  logic [7:0]    width_cfg,
   input  logic [6:0]    height_cfg,
   output pfbe_plan_type plan
);

   logic [8:0]  w_eff;
   logic [7:0]  h_eff;
   logic [4:0]  pages;
   logic        page_ok;
   logic        col_ok;
   logic [3:0]  cnt_sat;
   logic [7:0]  room;
   logic [3:0]  cnt;
   logic [7:0]  cnt_mask;
   logic [15:0] blit_bits;
   logic [15:0] blit_mask;

   // Saturate the registers to the store size
   assign w_eff = (9'(width_cfg) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(width_cfg);
   assign h_eff = (8'(height_cfg) > 8'(8 * MAX_PAGES)) ? 8'(8 * MAX_PAGES)
                                                       : 8'(height_cfg);
   assign pages = 5'((9'(h_eff) + 9'd7) >> 3);

   assign page_ok = 5'(page_sel) < pages;
   assign col_ok  = 9'(col_pos) < w_eff;

   // Clip the blit height to 8 and to the rows left below y
   assign cnt_sat  = (bit_count > 4'd8) ? 4'd8 : bit_count;
   assign room     = (h_eff > 8'(y_pos)) ? (h_eff - 8'(y_pos)) : 8'd0;
   assign cnt      = (8'(cnt_sat) > room) ? room[3:0] : cnt_sat;
   assign cnt_mask = 8'((9'd1 << cnt) - 9'd1);

   // Spread bits and mask over the first page (low byte) and the next (high byte)
   assign blit_bits = {8'd0, pix_bits & cnt_mask} << y_pos[2:0];
   assign blit_mask = {8'd0, cnt_mask} << y_pos[2:0];

   always_comb begin
      plan.op    = func;
      plan.page  = (func == OP_BLIT) ? y_pos[5:3] : page_sel;
      plan.col   = col_pos;
      plan.bits  = (func == OP_BLIT) ? blit_bits : {8'd0, pix_bits};
      plan.mask  = blit_mask;
      plan.width = w_eff;
      plan.pages = pages;
      unique case (func)
         OP_CLEAR_ALL:      plan.ok = 1'b1;
         OP_CLEAR_PAGE:     plan.ok = page_ok;
         OP_WRITE, OP_READ: plan.ok = page_ok && col_ok;
         OP_BLIT:           plan.ok = col_ok && (cnt != 4'd0);
         default:           plan.ok = 1'b0;
      endcase
   end

endmodule

FILE: design/pfbe_ctrl.sv
`timescale 1ns / 1ps

module pfbe_ctrl import pfbe_pkg::*; #(
   parameter int MAX_COLS  = 128,
   parameter int MAX_PAGES = 8,
   localparam int AW = $clog2(MAX_PAGES * MAX_COLS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   input  pfbe_plan_type plan,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_byte,
   output logic          rsp_status,
   output logic          rsp_last,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [7:0]    mem_wr_data,
   output logic          mem_rd_en,
   output logic [AW-1:0] mem_rd_addr,
   input  logic [7:0]    mem_rd_data
);

   localparam int CW  = $clog2(MAX_COLS + 1);
   localparam int PGW = $clog2(MAX_PAGES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SWEEP = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_BLIT1 = 3'd3;
   localparam logic [2:0] ST_BLIT2 = 3'd4;
   localparam logic [2:0] ST_HOLD  = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic [PGW-1:0] page_ff, page_in;
   logic [PGW-1:0] page_end_ff, page_end_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [CW-1:0]  col_end_ff, col_end_in;
   logic           silent_ff, silent_in;
   logic [15:0]    bits_ff, bits_in;
   logic [15:0]    mask_ff, mask_in;
   logic           fin_ff, fin_in;
   logic [7:0]     res_rd_ff, res_rd_in;
   logic           res_st_ff, res_st_in;
   logic           res_fin_ff, res_fin_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_status_ff, rsp_status_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           slot_free;
   logic           done;
   logic [7:0]     done_rd;
   logic           done_st;
   logic           done_fin;
   logic [PGW-1:0] page_next;

   function automatic logic [AW-1:0] cell_addr(input logic [4:0] pg, input logic [8:0] cl);
      return AW'(32'(pg) * 32'(MAX_COLS) + 32'(cl));
   endfunction

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign page_next  = PGW'(page_ff + PGW'(1));

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      page_end_in   = page_end_ff;
      col_in        = col_ff;
      col_end_in    = col_end_ff;
      silent_in     = silent_ff;
      bits_in       = bits_ff;
      mask_in       = mask_ff;
      fin_in        = fin_ff;
      res_rd_in     = res_rd_ff;
      res_st_in     = res_st_ff;
      res_fin_in    = res_fin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      done          = 1'b0;
      done_rd       = 8'd0;
      done_st       = 1'b0;
      done_fin      = fin_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = 8'd0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;

      unique case (state_ff)
         // Take a request and start its work
         ST_IDLE: begin
            if (req_valid) begin
               fin_in   = req_last;
               done_fin = req_last;
               page_in  = PGW'(plan.page);
               col_in   = CW'(plan.col);
               bits_in  = plan.bits;
               mask_in  = plan.mask;
               unique case (plan.op)
                  OP_CLEAR_ALL: begin
                     if (plan.width == 9'd0 || plan.pages == 5'd0) begin
                        done = 1'b1;
                     end else begin
                        state_in    = ST_SWEEP;
                        page_in     = '0;
                        page_end_in = PGW'(plan.pages);
                        col_in      = '0;
                        col_end_in  = CW'(plan.width);
                     end
                  end
                  OP_CLEAR_PAGE: begin
                     if (!plan.ok) begin
                        done    = 1'b1;
                        done_st = 1'b1;
                     end else if (plan.width == 9'd0) begin
                        done = 1'b1;
                     end else begin
                        state_in    = ST_SWEEP;
                        page_end_in = PGW'(5'(plan.page) + 5'd1);
                        col_in      = '0;
                        col_end_in  = CW'(plan.width);
                     end
                  end
                  OP_WRITE: begin
                     mem_wr_en   = plan.ok;
                     mem_wr_addr = cell_addr(5'(plan.page), 9'(plan.col));
                     mem_wr_data = plan.bits[7:0];
                     done        = 1'b1;
                     done_st     = !plan.ok;
                  end
                  OP_READ: begin
                     mem_rd_addr = cell_addr(5'(plan.page), 9'(plan.col));
                     if (plan.ok) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_READ;
                     end else begin
                        done    = 1'b1;
                        done_st = 1'b1;
                     end
                  end
                  OP_BLIT: begin
                     mem_rd_addr = cell_addr(5'(plan.page), 9'(plan.col));
                     if (plan.ok) begin
                        mem_rd_en = 1'b1;
                        state_in  = ST_BLIT1;
                     end else begin
                        done    = 1'b1;
                        done_st = 1'b1;
                     end
                  end
                  default: begin
                     done    = 1'b1;
                     done_st = 1'b1;
                  end
               endcase
            end
         end
         // Zero one entry per cycle, columns first, then pages
         ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cell_addr(5'(page_ff), 9'(col_ff));
            mem_wr_data = 8'd0;
            if ((CW + 1)'(col_ff) + (CW + 1)'(1) == (CW + 1)'(col_end_ff)) begin
               col_in = '0;
               if ((PGW + 1)'(page_ff) + (PGW + 1)'(1) == (PGW + 1)'(page_end_ff)) begin
                  done = 1'b1;
               end else begin
                  page_in = page_next;
               end
            end else begin
               col_in = CW'(col_ff + CW'(1));
            end
         end
         // Return the byte read at accept time
         ST_READ: begin
            done    = 1'b1;
            done_rd = mem_rd_data;
         end
         // Merge the first page; fetch the next page if the column spans it
         ST_BLIT1: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cell_addr(5'(page_ff), 9'(col_ff));
            mem_wr_data = pfbe_merge(mem_rd_data, bits_ff[7:0], mask_ff[7:0]);
            mem_rd_addr = cell_addr(5'(page_next), 9'(col_ff));
            if (mask_ff[15:8] != 8'd0) begin
               mem_rd_en = 1'b1;
               state_in  = ST_BLIT2;
            end else begin
               done = 1'b1;
            end
         end
         // Merge the lower page
         ST_BLIT2: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cell_addr(5'(page_next), 9'(col_ff));
            mem_wr_data = pfbe_merge(mem_rd_data, bits_ff[15:8], mask_ff[15:8]);
            done        = 1'b1;
         end
         // Hold a finished result until the output register frees up
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = res_rd_ff;
               rsp_status_in = res_st_ff;
               rsp_last_in   = res_fin_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Deliver the result, or park it; the power-up sweep has none
      if (done) begin
         if (silent_ff) begin
            silent_in = 1'b0;
            state_in  = ST_IDLE;
         end else if (slot_free) begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = done_rd;
            rsp_status_in = done_st;
            rsp_last_in   = done_fin;
            state_in      = ST_IDLE;
         end else begin
            res_rd_in  = done_rd;
            res_st_in  = done_st;
            res_fin_in = done_fin;
            state_in   = ST_HOLD;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         page_ff      <= '0;
         page_end_ff  <= PGW'(MAX_PAGES);
         col_ff       <= '0;
         col_end_ff   <= CW'(MAX_COLS);
         silent_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         page_ff      <= page_in;
         page_end_ff  <= page_end_in;
         col_ff       <= col_in;
         col_end_ff   <= col_end_in;
         silent_ff    <= silent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      bits_ff       <= bits_in;
      mask_ff       <= mask_in;
      fin_ff        <= fin_in;
      res_rd_ff     <= res_rd_in;
      res_st_ff     <= res_st_in;
      res_fin_ff    <= res_fin_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

FILE: design/page_framebuffer_blit_engine.sv
`timescale 1ns / 1ps

// Channel | Ports                                   | Payload
// --------+-----------------------------------------+---------------------------------------
// req     | req_tvalid req_tready req_tdata req_tuser req_tlast | command, position, pixel bits
// rsp     | rsp_tvalid rsp_tready rsp_tdata rsp_tlast | read byte, status, run end
// csr     | csr_we csr_index csr_wdata              | width in use, height in use
//
// Writes and rejected requests complete on acceptance; a read returns its byte from ST_READ,
// and a blit merges in ST_BLIT1, then in ST_BLIT2 if it spans two pages: the store read is registered.
// Clear page sweeps width entries, clear all width * pages entries: one store entry a cycle.
// After reset a sweep zeroes all MAX_PAGES * MAX_COLS store entries; req_tready stays low.
// A result parks in the output register, so the next request is taken while rsp stalls.
module page_framebuffer_blit_engine import pfbe_pkg::*; #(
   parameter int MAX_COLS  = 128,
   parameter int MAX_PAGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // page_sel[2:0], col_pos[9:3], y_pos[15:10], bit_count[19:16], pix_bits[27:20]
   input  logic [31:0] req_tdata,
   // func[2:0]
   input  logic [2:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_byte[7:0], status[8]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int DEPTH = MAX_PAGES * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0]    width_ff;
   logic [6:0]    height_ff;
   pfbe_plan_type plan;
   logic [7:0]    rsp_byte;
   logic          rsp_status;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_index == REG_HEIGHT) begin
            height_ff <= csr_wdata[6:0];
         end
      end
   end

   pfbe_decode #(
      .MAX_COLS  (MAX_COLS),
      .MAX_PAGES (MAX_PAGES)
   ) u_decode (
      .func       (req_tuser),
      .page_sel   (req_tdata[2:0]),
      .col_pos    (req_tdata[9:3]),
      .y_pos      (req_tdata[15:10]),
      .bit_count  (req_tdata[19:16]),
      .pix_bits   (req_tdata[27:20]),
      .width_cfg  (width_ff),
      .height_cfg (height_ff),
      .plan       (plan)
   );

   pfbe_ctrl #(
      .MAX_COLS  (MAX_COLS),
      .MAX_PAGES (MAX_PAGES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_last    (req_tlast),
      .plan        (plan),
      .req_ready   (req_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_byte    (rsp_byte),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_tlast),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   pfbe_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tdata = {7'd0, rsp_status, rsp_byte};

endmodule
